// ===== sv/ioir_pkg.sv =====
package ioir_pkg;

  // defaults for the module parameters
  localparam int unsigned RingDepthDef = 2048;
  localparam int unsigned MaxReportDef = 64;
  localparam int unsigned TimeWidthDef = 32;

  // fixed field widths
  localparam int unsigned IntervalW = 32;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned MaxPerW   = 7;

  // register reset values
  localparam logic [CfgDataW-1:0] MinIntervalRst = 32'd50;
  localparam logic [CfgDataW-1:0] MaxIntervalRst = 32'd100000;
  localparam int unsigned         ReportLimitRst = 64;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_INTERVAL = 2'd0,
    CFG_MAX_INTERVAL = 2'd1,
    CFG_REPORT_LIMIT = 2'd2
  } cfg_idx_e;

  // walk sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } walk_state_e;

endpackage

// ===== sv/inter_onset_interval_reporter_unit.sv =====
// Inter-onset interval reporter. Every accepted input word is one audio sample
// tick and advances the sample clock by one. A tick with onset_i set walks the
// onset-time ring from newest to oldest and sends one output word for every
// interval (now minus an earlier onset, modulo 2^TIME_WIDTH) that lies within
// [min_interval, max_interval]; the walk ends at the oldest stored onset, at
// the first interval above max_interval, or once the report limit of
// intervals has been found. last_o marks the final word of an onset; an onset
// with nothing to report sends a single word with has_interval_o low and
// interval_o zero. The onset time is then written into the ring. Every ring
// entry visited (at most RING_DEPTH) costs one read of the single-port ring
// memory plus a check of the data it returns; a full output register stalls
// the walk. Input is taken only while the walk sequencer is idle. Stored
// entries are tracked by a fill count, so there is no clearing pass after
// reset. Configuration (index 0 min_interval, 1 max_interval, 2 report
// limit) must be written only while the block is idle; a report limit is
// taken from the low MaxPerW bits of the data and ignored if these exceed
// MAX_REPORT, and unknown indexes are ignored.
module inter_onset_interval_reporter_unit
  import ioir_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RingDepthDef,
  parameter int unsigned MAX_REPORT = MaxReportDef,
  parameter int unsigned TIME_WIDTH = TimeWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // sample tick input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 onset_i,
  // interval output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IntervalW-1:0] interval_o,
  output logic                 has_interval_o,
  output logic                 last_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned PosW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned SeenW = $clog2(RING_DEPTH + 1);
  localparam int unsigned CntW  = (MAX_REPORT > 1) ? $clog2(MAX_REPORT + 1) : 1;
  localparam int unsigned CmpW  = (TIME_WIDTH > CfgDataW) ? TIME_WIDTH : CfgDataW;
  localparam int unsigned MaxPerRst =
    (ReportLimitRst < MAX_REPORT) ? ReportLimitRst : MAX_REPORT;

  // configuration registers
  logic [CfgDataW-1:0] min_q;
  logic [CfgDataW-1:0] max_q;
  logic [MaxPerW-1:0]  max_per_q;

  // walk state
  walk_state_e state_q, state_d;
  logic [TIME_WIDTH-1:0] clock_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic [PosW-1:0]       wp_q;
  logic [SeenW-1:0]      fill_q;
  logic [PosW-1:0]       pos_q;
  logic [SeenW-1:0]      seen_q;
  logic [CntW-1:0]       count_q;
  logic                  pend_valid_q;
  logic [TIME_WIDTH-1:0] pend_diff_q;

  // ring memory
  logic [TIME_WIDTH-1:0] ring_mem [RING_DEPTH];
  logic [TIME_WIDTH-1:0] rd_data_q;

  // output register
  logic                 out_valid_q;
  logic [IntervalW-1:0] out_interval_q;
  logic                 out_has_q;
  logic                 out_last_q;

  logic                  in_fire;
  logic                  out_free;
  logic [PosW-1:0]       pos_dec;
  logic [TIME_WIDTH-1:0] diff;
  logic [CmpW-1:0]       diff_ext;
  logic                  walk_stop;
  logic                  too_big;
  logic                  hit;
  logic                  mem_re;
  logic                  take_hit;
  logic                  push_mid;
  logic                  push_fin;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign in_fire        = in_valid_i & in_ready_o;
  assign out_free       = ~out_valid_q | out_ready_i;
  assign cfg_ready_o    = 1'b1;

  assign out_valid_o    = out_valid_q;
  assign interval_o     = out_interval_q;
  assign has_interval_o = out_has_q;
  assign last_o         = out_last_q;

  // step back one ring slot, wrapping below zero
  assign pos_dec  = (pos_q == '0) ? PosW'(RING_DEPTH - 1) : pos_q - 1'b1;
  assign diff     = now_q - rd_data_q;
  assign diff_ext = CmpW'(diff);

  // walk ends at the oldest stored entry or at the report limit
  assign walk_stop = (seen_q >= fill_q) || (MaxPerW'(count_q) >= max_per_q);
  assign too_big   = diff_ext > CmpW'(max_q);
  assign hit       = diff_ext >= CmpW'(min_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && onset_i) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = walk_stop ? ST_FINISH : ST_CHECK;
      end
      ST_CHECK: begin
        if (too_big) begin
          state_d = ST_FINISH;
        end else if (hit && pend_valid_q && !out_free) begin
          state_d = ST_CHECK;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer controls
  always_comb begin
    mem_re   = 1'b0;
    take_hit = 1'b0;
    push_mid = 1'b0;
    push_fin = 1'b0;
    case (state_q)
      ST_READ: begin
        mem_re = ~walk_stop;
      end
      ST_CHECK: begin
        // a new hit pushes the one held back, which now cannot be the last
        take_hit = ~too_big & hit & (~pend_valid_q | out_free);
        push_mid = take_hit & pend_valid_q;
      end
      ST_FINISH: begin
        push_fin = out_free;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= MinIntervalRst;
      max_q     <= MaxIntervalRst;
      max_per_q <= MaxPerW'(MaxPerRst);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_INTERVAL: min_q <= cfg_data_i;
        CFG_MAX_INTERVAL: max_q <= cfg_data_i;
        CFG_REPORT_LIMIT: begin
          if (cfg_data_i[MaxPerW-1:0] <= MaxPerW'(MAX_REPORT)) begin
            max_per_q <= cfg_data_i[MaxPerW-1:0];
          end
        end
        default: begin
          max_per_q <= max_per_q;
        end
      endcase
    end
  end

  // sample clock, ring write pointer and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= '0;
      wp_q    <= '0;
      fill_q  <= '0;
    end else begin
      if (in_fire) clock_q <= clock_q + 1'b1;
      if (push_fin) begin
        wp_q   <= (wp_q == PosW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
        fill_q <= (fill_q == SeenW'(RING_DEPTH)) ? fill_q : fill_q + 1'b1;
      end
    end
  end

  // walk counters and held-back hit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      seen_q       <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        pos_q        <= wp_q;
        seen_q       <= '0;
        count_q      <= '0;
        pend_valid_q <= 1'b0;
      end
      if (mem_re) begin
        pos_q  <= pos_dec;
        seen_q <= seen_q + 1'b1;
      end
      if (take_hit) begin
        pend_valid_q <= 1'b1;
        count_q      <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) now_q <= clock_q;
    if (take_hit) pend_diff_q <= diff;
  end

  // ring memory, one access per cycle
  always_ff @(posedge clk_i) begin
    if (push_fin) ring_mem[wp_q] <= now_q;
    if (mem_re) rd_data_q <= ring_mem[pos_dec];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_mid || push_fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_mid) begin
      out_interval_q <= IntervalW'(pend_diff_q);
      out_has_q      <= 1'b1;
      out_last_q     <= 1'b0;
    end else if (push_fin) begin
      out_interval_q <= pend_valid_q ? IntervalW'(pend_diff_q) : '0;
      out_has_q      <= pend_valid_q;
      out_last_q     <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the ring depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= SeenW'(RING_DEPTH))
    else $error("fill count above ring depth");

  // a walk never visits more entries than are stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (seen_q <= fill_q))
    else $error("walk passed the oldest stored entry");

  // hits found never exceed the report limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (MaxPerW'(count_q) <= max_per_q))
    else $error("report limit exceeded");

  // a finished walk closes the onset with a last word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_fin |=> (out_valid_q && out_last_q))
    else $error("onset not closed with last word");

  // the empty marker carries a zero interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_has_q) |-> (out_last_q && out_interval_q == '0))
    else $error("malformed empty marker");
`endif

endmodule
